// ===== rtl/emlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the edge max-label propagation block.
// Used by emlp_ctrl, emlp_datapath and edge_max_label_propagation.
package emlp_pkg;

    // Fixed field widths of the item and result ports
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;

    // Default vertex store depth
    localparam int VERTEX_COUNT_DEF = 1024;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EDGE = 3'b010,
        ST_READ = 3'b100
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic edge_update;  // compare and write back the fetched edge values
        logic read_capture; // move fetched read value into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;     // output register empty or draining this cycle
    } status_t;

endpackage

// ===== rtl/edge_max_label_propagation.sv =====
`timescale 1ns / 1ps
// Edge-centric max-label propagation over one graph partition. A load item
// (req_type 0) writes a value into the old and new vertex stores and clears
// the raise counter. An edge item (req_type 1) has an accept step and an
// update step: the accept step reads the old store at the source and the
// new store at the destination, the update step does the signed compare
// and writes the raised value back; this split is set by the single
// registered read port of each store. A read item (req_type 2) waits while
// the output register is still held by a stalled result. Unused code 3 is
// accepted and does nothing. Vertex stores hold no reset value: read only
// loaded vertices. Depends on emlp_pkg, emlp_ctrl and emlp_datapath.
module edge_max_label_propagation
    import emlp_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [IDX_W-1:0]  vertex_index,
    input  logic [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]  src_vertex,
    input  logic [IDX_W-1:0]  dst_vertex,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_value,
    output logic [DATA_W-1:0] update_count
);

    cmd_t    cmd;
    status_t status;
    state_t  state;

    emlp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd),
        .state    (state)
    );

    emlp_datapath #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .value        (value),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .update_count (update_count)
    );

    // An accepted edge occupies the following cycle for its write-back
    a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (req_type == REQ_EDGE)) |=> (in_stall && (state == ST_EDGE)))
        else $error("edge transfer not followed by update cycle");

    // A new result only appears from a read capture
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.read_capture))
        else $error("result appeared without read capture");

    // Capture never overwrites a stalled result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_capture |-> (!out_valid || !out_stall))
        else $error("read capture into held output register");

    // Transfers are taken only in idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (state == ST_IDLE))
        else $error("input transfer outside idle");

endmodule

// ===== rtl/emlp_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the edge max-label propagation block.
// Depends on emlp_pkg for state, command and status types.
module emlp_ctrl
    import emlp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [REQ_W-1:0] req_type,
    input  status_t          status,
    output logic             in_stall,
    output cmd_t             cmd,
    output state_t           state
);

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        in_stall         = 1'b1;
        cmd.accept       = 1'b0;
        cmd.edge_update  = 1'b0;
        cmd.read_capture = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (req_type == REQ_EDGE)
                        state_next = ST_EDGE;
                    else if (req_type == REQ_READ)
                        state_next = ST_READ;
                end
            end
            ST_EDGE:
            begin
                cmd.edge_update = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_READ:
            begin
                // wait until the output register can take the result
                cmd.read_capture = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

// ===== rtl/emlp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: old and new vertex value memories, raise counter, output register.
// Depends on emlp_pkg; driven by commands from emlp_ctrl.
module emlp_datapath
    import emlp_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [IDX_W-1:0]  vertex_index,
    input  logic [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]  src_vertex,
    input  logic [IDX_W-1:0]  dst_vertex,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_value,
    output logic [DATA_W-1:0] update_count
);

    localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    logic [DATA_W-1:0] old_mem [VERTEX_COUNT];
    logic [DATA_W-1:0] new_mem [VERTEX_COUNT];

    logic [DATA_W-1:0] old_rd_reg;
    logic [DATA_W-1:0] new_rd_reg;
    logic [ADDR_W-1:0] dst_addr_reg;
    logic              edge_ok_reg;
    logic              read_ok_reg;
    logic [DATA_W-1:0] count_reg;
    logic [DATA_W-1:0] count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] count_out_reg;

    logic              is_load;
    logic              is_edge;
    logic              is_read;
    logic              idx_ok;
    logic              src_ok;
    logic              dst_ok;
    logic [ADDR_W-1:0] idx_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [ADDR_W-1:0] new_rd_addr;
    logic              raise;
    logic              new_we;
    logic [ADDR_W-1:0] new_wr_addr;
    logic [DATA_W-1:0] new_wr_data;

    // Request decode and index range checks
    assign is_load  = cmd.accept && (req_type == REQ_LOAD);
    assign is_edge  = cmd.accept && (req_type == REQ_EDGE);
    assign is_read  = cmd.accept && (req_type == REQ_READ);
    assign idx_ok   = 32'(vertex_index) < 32'(VERTEX_COUNT);
    assign src_ok   = 32'(src_vertex) < 32'(VERTEX_COUNT);
    assign dst_ok   = 32'(dst_vertex) < 32'(VERTEX_COUNT);
    assign idx_addr = ADDR_W'(vertex_index);
    assign src_addr = ADDR_W'(src_vertex);
    assign dst_addr = ADDR_W'(dst_vertex);

    assign new_rd_addr = (req_type == REQ_EDGE) ? dst_addr : idx_addr;

    // Signed compare of fetched source and destination values
    assign raise = edge_ok_reg && ($signed(old_rd_reg) > $signed(new_rd_reg));

    // New store write port: load at transfer, or raise on edge update
    always_comb
    begin
        new_we      = 1'b0;
        new_wr_addr = idx_addr;
        new_wr_data = value;
        if (cmd.edge_update)
        begin
            new_we      = raise;
            new_wr_addr = dst_addr_reg;
            new_wr_data = old_rd_reg;
        end
        else if (is_load && idx_ok)
        begin
            new_we = 1'b1;
        end
    end

    // Old value memory
    always_ff @(posedge clk)
    begin
        if (is_load && idx_ok)
            old_mem[idx_addr] <= value;
        if (is_edge)
            old_rd_reg <= old_mem[src_addr];
    end

    // New value memory
    always_ff @(posedge clk)
    begin
        if (new_we)
            new_mem[new_wr_addr] <= new_wr_data;
        if (is_edge || is_read)
            new_rd_reg <= new_mem[new_rd_addr];
    end

    // Item context held across the fetch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dst_addr_reg <= dst_addr;
            read_ok_reg  <= idx_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            edge_ok_reg <= 1'b0;
        else if (cmd.accept)
            edge_ok_reg <= is_edge && src_ok && dst_ok;
    end

    // Raise counter: cleared by loads, saturating increment
    always_comb
    begin
        count_next = count_reg;
        if (is_load)
            count_next = '0;
        else if (cmd.edge_update && raise && (count_reg != '1))
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Output register
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.read_capture)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_capture)
        begin
            read_value_reg <= read_ok_reg ? new_rd_reg : '0;
            count_out_reg  <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign update_count = count_out_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for edge_max_label_propagation: directed and random
// load / edge / read traffic checked against an in-bench label predictor.
// Depends on emlp_pkg and the edge_max_label_propagation RTL.
module tb;
    import emlp_pkg::*;

    localparam int VTX            = VERTEX_COUNT_DEF;
    localparam int PASS_ITEMS     = 310;   // counted items per idling phase
    localparam int HOLD_CYCLES    = 200;   // one long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all

    // Code 3 has no meaning in the block; it must be dropped
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  dst;
    } vertex_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] label;
        logic [DATA_W-1:0] raises;
    } read_result_t;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [REQ_W-1:0]  req_type     = '0;
    logic [IDX_W-1:0]  vertex_index = '0;
    logic [DATA_W-1:0] value        = '0;
    logic [IDX_W-1:0]  src_vertex   = '0;
    logic [IDX_W-1:0]  dst_vertex   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] update_count;

    edge_max_label_propagation #(
        .VERTEX_COUNT(VTX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .value        (value),
        .src_vertex   (src_vertex),
        .dst_vertex   (dst_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .update_count (update_count)
    );

    // Stimulus bookkeeping
    vertex_req_t  pending_reqs [$];
    read_result_t expected_reads [$];
    int unsigned  loaded_list [$];
    int unsigned  pass_group [$];
    bit           loaded_map [VTX];
    int           gen_count;

    // Predictor state
    logic [DATA_W-1:0] old_labels [VTX];
    logic [DATA_W-1:0] new_labels [VTX];
    logic [DATA_W-1:0] raise_count = '0;

    // Handshake and run control
    logic in_fire   = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_go   = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt  = 0;
    int   idle_cycles = 0;

    // Coverage counters for the summary
    int errors        = 0;
    int n_loads       = 0;
    int n_edges       = 0;
    int n_raised      = 0;
    int n_unused      = 0;
    int reads_checked = 0;
    int stalled_in    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
        errors++;
    endtask

    function automatic int unsigned pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic int unsigned pick_group();
        return pass_group[$urandom_range(pass_group.size() - 1)];
    endfunction

    // Mix of full-range, near-zero (so ties happen) and extreme labels
    function automatic logic [DATA_W-1:0] pick_label();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Fields a request does not use are randomized so every bit toggles
    task automatic add_load(input int unsigned idx, input logic [DATA_W-1:0] val);
        vertex_req_t r;
        r.req = REQ_LOAD;
        r.idx = IDX_W'(idx);
        r.val = val;
        r.src = IDX_W'($urandom_range(VTX - 1));
        r.dst = IDX_W'($urandom_range(VTX - 1));
        pending_reqs.push_back(r);
        if (!loaded_map[idx])
        begin
            loaded_map[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        gen_count++;
    endtask

    task automatic add_edge(input int unsigned src, input int unsigned dst);
        vertex_req_t r;
        r.req = REQ_EDGE;
        r.idx = IDX_W'($urandom_range(VTX - 1));
        r.val = $urandom;
        r.src = IDX_W'(src);
        r.dst = IDX_W'(dst);
        pending_reqs.push_back(r);
        gen_count++;
    endtask

    task automatic add_read(input int unsigned idx);
        vertex_req_t r;
        r.req = REQ_READ;
        r.idx = IDX_W'(idx);
        r.val = $urandom;
        r.src = IDX_W'($urandom_range(VTX - 1));
        r.dst = IDX_W'($urandom_range(VTX - 1));
        pending_reqs.push_back(r);
        gen_count++;
    endtask

    task automatic add_unused();
        vertex_req_t r;
        r.req = REQ_UNUSED;
        r.idx = IDX_W'($urandom_range(VTX - 1));
        r.val = $urandom;
        r.src = IDX_W'($urandom_range(VTX - 1));
        r.dst = IDX_W'($urandom_range(VTX - 1));
        pending_reqs.push_back(r);
    endtask

    // One propagation pass: load a vertex group, stream edges over it with
    // reads mixed in; a stray load mid-pass clears the counter early.
    task automatic add_random_pass();
        int unsigned idx;
        int unsigned roll;
        int          n;
        pass_group.delete();
        n = $urandom_range(10, 2);
        repeat (n)
        begin
            if ($urandom_range(7) == 0)
                idx = $urandom_range(1) ? VTX - 1 : 0;
            else
                idx = $urandom_range(VTX - 1);
            add_load(idx, pick_label());
            pass_group.push_back(idx);
        end
        n = $urandom_range(40, 4);
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 62)
                add_edge(pick_group(), pick_group());
            else if (roll < 72)
                add_edge(pick_loaded(), pick_group());
            else if (roll < 85)
                add_read(pick_group());
            else if (roll < 90)
                add_read(pick_loaded());
            else if (roll < 95)
            begin
                idx = $urandom_range(VTX - 1);
                add_load(idx, pick_label());
                pass_group.push_back(idx);
            end
            else
                add_unused();
        end
        repeat ($urandom_range(3, 1))
            add_read(pick_group());
    endtask

    // Sender: new item only when the line is free or the last one transferred
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_type     <= pending_reqs[0].req;
                vertex_index <= pending_reqs[0].idx;
                value        <= pending_reqs[0].val;
                src_vertex   <= pending_reqs[0].src;
                dst_vertex   <= pending_reqs[0].dst;
                void'(pending_reqs.pop_front());
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall, plus one long hold once a result is waiting
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_go && !hold_done && out_valid)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: check result transfers, then predict from input transfers
    always @(posedge clk)
    begin : monitor
        read_result_t      want;
        logic [DATA_W-1:0] cand;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && in_stall)
                stalled_in++;

            if (out_valid && !out_stall)
            begin
                if (expected_reads.size() == 0)
                    report_mismatch("result with no read pending", '0, read_value);
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_value !== want.label)
                        report_mismatch("read_value", want.label, read_value);
                    if (update_count !== want.raises)
                        report_mismatch("update_count", want.raises, update_count);
                    reads_checked++;
                end
            end

            if (in_valid && !in_stall)
            begin
                case (req_type)
                    REQ_LOAD:
                    begin
                        if (vertex_index < VTX)
                        begin
                            old_labels[vertex_index] = value;
                            new_labels[vertex_index] = value;
                        end
                        raise_count = '0;
                        n_loads++;
                    end
                    REQ_EDGE:
                    begin
                        // signed max; ties and smaller sources leave the label
                        if (src_vertex < VTX && dst_vertex < VTX)
                        begin
                            cand = old_labels[src_vertex];
                            if ($signed(cand) > $signed(new_labels[dst_vertex]))
                            begin
                                new_labels[dst_vertex] = cand;
                                if (raise_count != '1)
                                    raise_count = raise_count + 1'b1;
                                n_raised++;
                            end
                        end
                        n_edges++;
                    end
                    REQ_READ:
                    begin
                        want.label  = (vertex_index < VTX) ? new_labels[vertex_index] : '0;
                        want.raises = raise_count;
                        expected_reads.push_back(want);
                    end
                    default:
                        n_unused++;
                endcase
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no transfer for %0d cycles", idle_cycles);
                $display("edge_max_label_propagation: mismatch");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence
    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme labels, raise / no raise / tie, self loop,
        // unused code, counter clear on load, back-to-back dependent items
        add_load(0, 32'h7FFF_FFFF);
        add_load(VTX - 1, 32'h8000_0000);
        add_load(512, 32'h0000_0000);
        add_load(1, 32'hFFFF_FFFF);
        add_read(0);
        add_edge(0, VTX - 1);
        add_edge(VTX - 1, 512);
        add_read(VTX - 1);
        add_edge(512, 1);
        add_load(2, 32'h0000_0000);
        add_edge(512, 2);
        add_edge(1, 1);
        add_edge(VTX - 1, 0);
        add_read(1);
        add_read(2);
        pending_reqs.push_back('{REQ_UNUSED, '1, '1, '1, '1});
        add_read(512);
        add_load(0, 32'h7FFF_FFFF);
        add_read(VTX - 1);
        add_edge(0, VTX - 1);
        add_read(VTX - 1);
        add_load(3, 32'h0000_0001);
        add_edge(3, 512);
        add_read(512);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_go       = 1'b1;
                end
            endcase
            gen_count = 0;
            while (gen_count < PASS_ITEMS)
                add_random_pass();
            while (pending_reqs.size() != 0 || in_valid || expected_reads.size() != 0)
                @(posedge clk);
        end

        repeat (8) @(posedge clk);
        $display("covered %0d loads, %0d edges (%0d raised a label), %0d reads checked,",
                 n_loads, n_edges, n_raised, reads_checked);
        $display("%0d unused codes, %0d vertices loaded, input stalled %0d cycles",
                 n_unused, loaded_list.size(), stalled_in);
        if (errors == 0)
            $display("edge_max_label_propagation: match");
        else
            $display("edge_max_label_propagation: mismatch");
        $finish;
    end

endmodule
